// File: hdl/cdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_pkg: shared types and constants of the coordinate deque
// Command and status codes, the default sizes, and the small structs passed
// between the sequencer, the entry store and the top level.
// ----------------------------------------------------------------------------
package cdl_pkg;

   localparam int CDL_CAPACITY   = 256;
   localparam int CDL_COORD_BITS = 8;
   localparam int CDL_CMD_BITS   = 3;
   localparam int CDL_STAT_BITS  = 2;

   typedef enum logic [CDL_CMD_BITS-1:0] {
      CMD_CLEAR      = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_FIND       = 3'd4,
      CMD_REMOVE     = 3'd5,
      CMD_QUERY      = 3'd6
   } cmd_type;

   typedef enum logic [CDL_STAT_BITS-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // Port strobes of the entry store.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // Flags of one result word; status sits in the low bits.
   typedef struct packed {
      logic       found;
      status_type status;
   } rsp_flags_type;

endpackage

// File: hdl/coordinate_deque_with_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_deque_with_lookup_core: ordered list of (x,y) pairs with search
// A ring of CAPACITY pairs in one synchronous memory, a command sequencer
// that pushes, pops, searches and closes gaps, and a registered result port.
// ----------------------------------------------------------------------------
//
//  Channel  Ports   Direction  Contents of one word
//  -------  ------  ---------  ---------------------------------------------
//  command  req_*   in         tuser: cmd; tdata: item_x, item_y
//  result   rsp_*   out        tuser: status, found; tdata: popped_x,
//                              popped_y, front_x, front_y, count
//
// Clear, push and query need no read of the entry memory, nor does any command
// on an empty list. Pop back reads the last entry. Find walks the entries from
// the front until the pair matches or the list ends; remove walks the whole
// list, moving every entry behind the match one place toward the front. The
// single read port of the entry memory is walked one entry per cycle.
// Reset clears the entry count and the ring head; memory content is not
// touched. A stalled result waits in the output register while the next
// command is already taken; a second finished result waits in the sequencer.
//
module coordinate_deque_with_lookup_core
   import cdl_pkg::*;
#(
   parameter int CAPACITY   = CDL_CAPACITY,
   parameter int COORD_BITS = CDL_COORD_BITS,
   localparam int PTR_W      = $clog2(CAPACITY),
   localparam int CNT_W      = $clog2(CAPACITY + 1),
   localparam int PAIR_W     = 2 * COORD_BITS,
   localparam int REQ_DATA_W = ((PAIR_W + 7) / 8) * 8,
   localparam int RSP_BITS   = 2 * PAIR_W + CNT_W,
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // command words
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_W-1:0]     req_tdata,   // item_x, item_y
   input  logic [CDL_CMD_BITS-1:0]   req_tuser,   // cmd
   // result words
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_W-1:0]     rsp_tdata,   // popped_x, popped_y, front_x,
                                                  // front_y, count
   output logic [CDL_STAT_BITS:0]    rsp_tuser    // status, found
);

   mem_ctl_type          mem_ctl;
   logic [PTR_W-1:0]     mem_wr_addr;
   logic [PTR_W-1:0]     mem_rd_addr;
   logic [PAIR_W-1:0]    mem_wr_data;
   logic [PAIR_W-1:0]    mem_rd_data;

   logic                 res_valid;
   logic                 res_ready;
   rsp_flags_type        res_flags;
   logic [PAIR_W-1:0]    res_popped;
   logic [PAIR_W-1:0]    res_front;
   logic [CNT_W-1:0]     res_count;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_flags_type        rsp_flags_ff;
   logic [RSP_BITS-1:0]  rsp_bits_ff;

   // The pair travels as {y, x} with x in the low bits, as on the bus.
   cdl_ctrl #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS),
      .PTR_W      (PTR_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (cmd_type'(req_tuser)),
      .req_item    (req_tdata[PAIR_W-1:0]),
      .mem_ctl     (mem_ctl),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_flags   (res_flags),
      .res_popped  (res_popped),
      .res_front   (res_front),
      .res_count   (res_count)
   );

   cdl_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (PTR_W),
      .DATA_W (PAIR_W)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: it loads whenever it is empty or being drained, so the
   // sequencer only waits when a result is stuck here.
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_flags_ff <= res_flags;
         rsp_bits_ff  <= {res_count, res_front, res_popped};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flags_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_bits_ff);

endmodule

// File: hdl/cdl_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_store: entry memory of the coordinate deque
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module cdl_store
   import cdl_pkg::*;
#(
   parameter int DEPTH  = CDL_CAPACITY,
   parameter int ADDR_W = $clog2(CDL_CAPACITY),
   parameter int DATA_W = 2 * CDL_COORD_BITS
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cdl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_ctrl: command sequencer of the coordinate deque
// Keeps the ring pointers, walks the entry store for search and gap closing,
// and holds the result of the current command until it is handed on.
// ----------------------------------------------------------------------------
module cdl_ctrl
   import cdl_pkg::*;
#(
   parameter int CAPACITY   = CDL_CAPACITY,
   parameter int COORD_BITS = CDL_COORD_BITS,
   parameter int PTR_W      = $clog2(CDL_CAPACITY),
   parameter int CNT_W      = $clog2(CDL_CAPACITY + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   // command side
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cmd_type                 req_cmd,
   input  logic [2*COORD_BITS-1:0] req_item,
   // entry store
   output mem_ctl_type             mem_ctl,
   output logic [PTR_W-1:0]        mem_wr_addr,
   output logic [2*COORD_BITS-1:0] mem_wr_data,
   output logic [PTR_W-1:0]        mem_rd_addr,
   input  logic [2*COORD_BITS-1:0] mem_rd_data,
   // result side
   output logic                    res_valid,
   input  logic                    res_ready,
   output rsp_flags_type           res_flags,
   output logic [2*COORD_BITS-1:0] res_popped,
   output logic [2*COORD_BITS-1:0] res_front,
   output logic [CNT_W-1:0]        res_count
);

   localparam int PAIR_W = 2 * COORD_BITS;
   localparam logic [PTR_W:0]   CAP_EXT  = (PTR_W + 1)'(CAPACITY);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_POP   = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            cmd_ff, cmd_in;
   logic [PAIR_W-1:0]  item_ff, item_in;
   logic [PTR_W-1:0]   idx_ff, idx_in;
   status_type         status_ff, status_in;
   logic               found_ff, found_in;
   logic [PAIR_W-1:0]  popped_ff, popped_in;
   logic [PAIR_W-1:0]  front_ff, front_in;

   logic [PTR_W-1:0]   head_dec;
   logic [CNT_W-1:0]   idx_ext;
   logic               is_empty;
   logic               is_full;
   logic               more_one;
   logic               more_two;

   // Logical position to ring address.
   function automatic logic [PTR_W-1:0] to_phys(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] offs);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= CAP_EXT) begin
         sum = sum - CAP_EXT;
      end
      return sum[PTR_W-1:0];
   endfunction

   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - PTR_W'(1);
   assign idx_ext  = CNT_W'(idx_ff);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == FULL_CNT);
   assign more_one = (idx_ext + CNT_W'(1)) < count_ff;
   assign more_two = (idx_ext + CNT_W'(2)) < count_ff;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      item_in     = item_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      popped_in   = popped_ff;
      front_in    = front_ff;
      mem_ctl     = '0;
      mem_wr_addr = '0;
      mem_wr_data = req_item;
      mem_rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               item_in   = req_item;
               idx_in    = '0;
               status_in = STAT_OK;
               found_in  = 1'b0;
               popped_in = '0;
               state_in  = S_DONE;
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     head_in  = '0;
                  end
                  CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        mem_wr_addr   = head_dec;
                        head_in       = head_dec;
                        count_in      = count_ff + CNT_W'(1);
                        front_in      = req_item;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        mem_wr_addr   = to_phys(head_ff, count_ff[PTR_W-1:0]);
                        count_in      = count_ff + CNT_W'(1);
                        if (is_empty) begin
                           front_in = req_item;
                        end
                     end
                  end
                  CMD_POP_BACK: begin
                     if (is_empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = to_phys(head_ff,
                                                PTR_W'(count_ff - CNT_W'(1)));
                        count_in      = count_ff - CNT_W'(1);
                        state_in      = S_POP;
                     end
                  end
                  CMD_FIND, CMD_REMOVE: begin
                     if (is_empty) begin
                        status_in = STAT_NOT_FOUND;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = head_ff;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                     if (is_empty) begin
                        status_in = STAT_EMPTY;
                     end
                  end
               endcase
            end
         end
         S_POP: begin
            popped_in = mem_rd_data;
            state_in  = S_DONE;
         end
         S_SCAN: begin
            // Read data belongs to position idx_ff; the next read is already
            // issued here so the walk covers one entry per cycle.
            if (mem_rd_data == item_ff) begin
               found_in = 1'b1;
               state_in = S_DONE;
               if (cmd_ff == CMD_REMOVE) begin
                  if (more_one) begin
                     mem_ctl.rd_en = 1'b1;
                     mem_rd_addr   = to_phys(head_ff, PTR_W'(idx_ext + CNT_W'(1)));
                     state_in      = S_SHIFT;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end else if (more_one) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = to_phys(head_ff, PTR_W'(idx_ext + CNT_W'(1)));
               idx_in        = PTR_W'(idx_ext + CNT_W'(1));
            end else begin
               status_in = STAT_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_SHIFT: begin
            // Entry idx_ff+1 arrives and is written one place toward the
            // front; the read two places ahead never hits the written entry.
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = to_phys(head_ff, idx_ff);
            mem_wr_data   = mem_rd_data;
            if (idx_ff == '0) begin
               front_in = mem_rd_data;
            end
            if (more_two) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = to_phys(head_ff, PTR_W'(idx_ext + CNT_W'(2)));
               idx_in        = PTR_W'(idx_ext + CNT_W'(1));
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      item_ff   <= item_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      popped_ff <= popped_in;
      front_ff  <= front_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign res_valid        = (state_ff == S_DONE);
   assign res_flags.status = status_ff;
   assign res_flags.found  = found_ff;
   assign res_popped       = popped_ff;
   assign res_front        = is_empty ? '0 : front_ff;
   assign res_count        = count_ff;

endmodule
